// ===== rtl/core/x86_integer_alu_with_flags_macros.svh =====
// Assertion macros for the x86 integer ALU.
// Used by the top level only; no other dependencies.
`ifndef X86_INTEGER_ALU_WITH_FLAGS_MACROS_SVH
`define X86_INTEGER_ALU_WITH_FLAGS_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ALU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define ALU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/core/xalu_pkg.sv =====
// Shared types and constants for the x86 integer ALU.
// No dependencies.
`timescale 1ns / 1ps
package xalu_pkg;
	localparam int unsigned DataWidth = 32;
	localparam int unsigned DivSteps  = 64;

	typedef enum logic [3:0] {
		OP_ADD, OP_ADC, OP_SUB, OP_SBB, OP_AND, OP_OR, OP_XOR, OP_SHL,
		OP_SHR, OP_SAR, OP_MUL, OP_IMUL, OP_DIV, OP_IDIV, OP_MOD, OP_IMOD
	} op_t;

	// Classified word handed from the front to the back.
	typedef struct packed {
		op_t         op;
		logic [5:0]  w;      // operand width: 8, 16 or 32
		logic [31:0] s;      // source masked to width
		logic [31:0] d;      // destination masked to width
		logic [31:0] dfull;  // destination as given, low half of the dividend
		logic [31:0] upper;
	} item_t;

	typedef struct packed {
		logic [31:0] lo;
		logic [31:0] hi;
		logic [4:0]  flags;  // CF, PF, ZF, SF, OF from bit 0
		logic        derr;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_DIV, ST_FIX, ST_DONE
	} bstate_t;

	function automatic logic [31:0] wmask(input logic [5:0] w);
		return (w == 6'd8) ? 32'hff : (w == 6'd16) ? 32'hffff : 32'hffffffff;
	endfunction

	function automatic logic topbit(input logic [31:0] v, input logic [5:0] w);
		return (w == 6'd8) ? v[7] : (w == 6'd16) ? v[15] : v[31];
	endfunction

	function automatic logic [63:0] sx64(input logic [31:0] v, input logic [5:0] w);
		return topbit(v, w) ? ({32'hffffffff, v & wmask(w)} | {32'hffffffff, ~wmask(w)})
			: {32'd0, v & wmask(w)};
	endfunction
endpackage

// ===== rtl/core/xalu_front.sv =====
// Front end of the x86 ALU: accepts words and classifies them by width.
// Depends on xalu_pkg.
`timescale 1ns / 1ps
module xalu_front import xalu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  op,
	input  logic [1:0]  size_code,
	input  logic [31:0] src_operand,
	input  logic [31:0] dest_operand,
	input  logic [31:0] dest_upper,
	output logic        q_valid,
	input  logic        q_ready,
	output item_t       q_item
);
	item_t item_q;
	logic  valid_q;
	logic [5:0] w;

	assign w = (size_code == 2'd0) ? 6'd8 : (size_code == 2'd1) ? 6'd16 : 6'd32;
	assign in_ready = !valid_q || q_ready;
	assign q_valid = valid_q;
	assign q_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q.op    <= op_t'(op);
			item_q.w     <= w;
			item_q.s     <= src_operand & wmask(w);
			item_q.d     <= dest_operand & wmask(w);
			item_q.dfull <= dest_operand;
			item_q.upper <= dest_upper;
		end
	end
endmodule

// ===== rtl/core/xalu_back.sv =====
// Back end of the x86 ALU: executes one word, keeps the flag register.
// Depends on xalu_pkg.
`timescale 1ns / 1ps
module xalu_back import xalu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_valid,
	output logic  q_ready,
	input  item_t q_item,
	output logic  r_valid,
	input  logic  r_ready,
	output res_t  r_res
);
	bstate_t state_q, state_d;
	item_t   it_q;
	logic [4:0]  flags_q;
	res_t        res_q;
	logic [63:0] prod_q;
	logic [63:0] rem_q;   // partial remainder / dividend shift
	logic [63:0] quo_q;
	logic [63:0] dvs_q;
	logic        nn_q, dn_q;
	logic [6:0]  cnt_q;

	logic [63:0] ua, ub;
	logic        nn, dn, signed_div;
	logic [4:0]  nf;
	logic [31:0] lo;
	logic [31:0] cnt;
	logic [63:0] sxd, sar_r;
	logic [32:0] sum;
	logic [33:0] subw;
	logic        cin, cf_new;
	logic [63:0] rem_sh;
	logic [64:0] trial;
	logic [63:0] q_fix, r_fix;
	logic [63:0] mul_a, mul_b;
	logic signed [65:0] prod_w;
	logic        mul_ovf;

	function automatic logic [4:0] pzs(input logic [4:0] f, input logic [31:0] r,
		input logic [5:0] w);
		logic [4:0] o;
		o = f;
		o[1] = ~^r[7:0];
		o[2] = ((r & wmask(w)) == 32'd0);
		o[3] = topbit(r, w);
		return o;
	endfunction

	assign signed_div = (it_q.op == OP_IDIV) || (it_q.op == OP_IMOD);
	assign q_ready = (state_q == ST_IDLE);
	assign r_valid = (state_q == ST_DONE);
	assign r_res = res_q;

	// Operand magnitudes for the divider, taken from the queue head.
	always_comb begin
		logic sd;
		logic [63:0] dvd;
		sd = (q_item.op == OP_IDIV) || (q_item.op == OP_IMOD);
		dvd = {q_item.upper, q_item.dfull};
		nn = sd && dvd[63];
		dn = sd && topbit(q_item.s, q_item.w);
		ua = nn ? 64'd0 - dvd : dvd;
		ub = dn ? 64'd0 - sx64(q_item.s, q_item.w) : {32'd0, q_item.s};
	end

	// Logic, add, subtract and shift operations computed combinationally from the captured word.
	always_comb begin
		nf = flags_q;
		lo = 32'd0;
		cnt = {27'd0, it_q.s[4:0]};
		cin = flags_q[0];
		sum = 33'd0;
		subw = 34'd0;
		cf_new = 1'b0;
		sxd = sx64(it_q.d, it_q.w);
		sar_r = 64'd0;
		case (it_q.op)
			OP_ADD, OP_ADC: begin
				sum = {1'b0, it_q.s} + {1'b0, it_q.d}
					+ {32'd0, (it_q.op == OP_ADC) & cin};
				lo = sum[31:0] & wmask(it_q.w);
				nf[0] = sum[it_q.w];
				nf[4] = topbit(~(it_q.d ^ it_q.s) & (it_q.d ^ lo), it_q.w);
				nf = pzs(nf, lo, it_q.w);
			end
			OP_SUB, OP_SBB: begin
				subw = {2'b0, it_q.d} - {2'b0, it_q.s}
					- {33'd0, (it_q.op == OP_SBB) & cin};
				lo = subw[31:0] & wmask(it_q.w);
				nf[0] = subw[33];
				nf[4] = topbit((it_q.d ^ it_q.s) & (it_q.d ^ lo), it_q.w);
				nf = pzs(nf, lo, it_q.w);
			end
			OP_AND, OP_OR, OP_XOR: begin
				lo = (it_q.op == OP_AND) ? (it_q.s & it_q.d)
					: (it_q.op == OP_OR) ? (it_q.s | it_q.d) : (it_q.s ^ it_q.d);
				nf[0] = 1'b0;
				nf[4] = 1'b0;
				nf = pzs(nf, lo, it_q.w);
			end
			OP_SHL: begin
				lo = it_q.d;
				if (cnt != 32'd0) begin
					lo = (it_q.d << cnt[4:0]) & wmask(it_q.w);
					cf_new = (cnt <= {26'd0, it_q.w})
						? it_q.d[5'(it_q.w - cnt[5:0])] : 1'b0;
					nf[0] = cf_new;
					if (cnt == 32'd1) nf[4] = topbit(lo, it_q.w) ^ cf_new;
					nf = pzs(nf, lo, it_q.w);
				end
			end
			OP_SHR: begin
				lo = it_q.d;
				if (cnt != 32'd0) begin
					lo = it_q.d >> cnt[4:0];
					nf[0] = (cnt <= {26'd0, it_q.w}) ? it_q.d[5'(cnt - 32'd1)] : 1'b0;
					if (cnt == 32'd1) nf[4] = topbit(it_q.d, it_q.w);
					nf = pzs(nf, lo, it_q.w);
				end
			end
			OP_SAR: begin
				lo = it_q.d;
				if (cnt != 32'd0) begin
					sar_r = $unsigned($signed(sxd) >>> cnt[4:0]);
					lo = sar_r[31:0] & wmask(it_q.w);
					nf[0] = sxd[6'(cnt - 32'd1)];
					if (cnt == 32'd1) nf[4] = 1'b0;
					nf = pzs(nf, lo, it_q.w);
				end
			end
			default: begin
			end
		endcase
	end

	// Divider step: restoring, one quotient bit per cycle.
	assign rem_sh = {rem_q[62:0], quo_q[63]};
	assign trial = {1'b0, rem_sh} - {1'b0, dvs_q};
	assign q_fix = (nn_q != dn_q) ? 64'd0 - quo_q : quo_q;
	assign r_fix = nn_q ? 64'd0 - rem_q : rem_q;
	assign mul_a = (it_q.op == OP_IMUL) ? sx64(it_q.s, it_q.w) : {32'd0, it_q.s};
	assign mul_b = (it_q.op == OP_IMUL) ? sx64(it_q.d, it_q.w) : {32'd0, it_q.d};

	// A 33 by 33 signed product covers both the unsigned and the signed multiply.
	assign prod_w = $signed(mul_a[32:0]) * $signed(mul_b[32:0]);
	assign mul_ovf = (it_q.op == OP_IMUL) ? (prod_q != sx64(prod_q[31:0], it_q.w))
		: ((prod_q >> it_q.w) != 64'd0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (q_valid) state_d = ST_MUL;
			ST_MUL: begin
				if (it_q.op inside {OP_DIV, OP_IDIV, OP_MOD, OP_IMOD} && it_q.s != 32'd0)
					state_d = ST_DIV;
				else if (it_q.op inside {OP_MUL, OP_IMUL})
					state_d = ST_FIX;
				else
					state_d = ST_DONE;
			end
			ST_DIV: if (cnt_q == 7'(DivSteps - 1)) state_d = ST_FIX;
			ST_FIX: state_d = ST_DONE;
			ST_DONE: if (r_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			flags_q <= 5'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MUL && !(it_q.op inside {OP_MUL, OP_IMUL, OP_DIV,
				OP_IDIV, OP_MOD, OP_IMOD}))
				flags_q <= nf;
			if (state_q == ST_FIX && it_q.op inside {OP_MUL, OP_IMUL}) begin
				flags_q[0] <= mul_ovf;
				flags_q[4] <= mul_ovf;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				it_q <= q_item;
				rem_q <= 64'd0;
				quo_q <= ua;
				dvs_q <= ub;
				nn_q <= nn;
				dn_q <= dn;
				cnt_q <= 7'd0;
			end
			ST_MUL: begin
				prod_q <= prod_w[63:0];
				res_q.lo <= lo;
				res_q.hi <= 32'd0;
				res_q.flags <= nf;
				res_q.derr <= it_q.op inside {OP_DIV, OP_IDIV, OP_MOD, OP_IMOD}
					&& it_q.s == 32'd0;
			end
			ST_DIV: begin
				cnt_q <= cnt_q + 7'd1;
				if (!trial[64]) begin
					rem_q <= trial[63:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end
			ST_FIX: begin
				if (it_q.op inside {OP_MUL, OP_IMUL}) begin
					res_q.lo <= prod_q[31:0];
					res_q.hi <= prod_q[63:32];
					res_q.flags <= {mul_ovf, flags_q[3:1], mul_ovf};
				end else begin
					res_q.lo <= ((it_q.op == OP_DIV || it_q.op == OP_IDIV)
						? q_fix[31:0] : r_fix[31:0]) & wmask(it_q.w);
					res_q.flags <= flags_q;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

// ===== rtl/core/x86_integer_alu_with_flags.sv =====
// Top level of the x86 integer ALU with flags.
// Depends on xalu_pkg, xalu_front, xalu_back and the assertion macro header.
`timescale 1ns / 1ps
`include "x86_integer_alu_with_flags_macros.svh"
// Usage: the slave channel (s_tvalid/s_tready/s_tdata) takes one word per
// operation; the master channel (m_tvalid/m_tready/m_tdata) returns one word.
// The front stage registers and classifies each word; a one-entry queue
// separates it from the back end, which owns the flag register.
// Path of a word: the front register, then the back end captures it and
// enters MUL; logic, add and shift ops and a zero divisor go on to DONE,
// multiplies pass through FIX, and divisions run the 64-step radix-2
// restoring divider loop before FIX. The back end runs one word at a time.
// Reset clears the flag register (all flags zero) and empties both stages.
// When the receiver stalls, the result holds in the output register and
// the front stage still takes one more word into the queue.
module x86_integer_alu_with_flags import xalu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// op[3:0], size_code[5:4], src_operand[37:6], dest_operand[69:38],
	// dest_upper[101:70], zeros above
	input  logic [103:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// result_low[31:0], result_high[63:32], carry_flag[64], parity_flag[65],
	// zero_flag[66], sign_flag[67], overflow_flag[68], divide_error[69]
	output logic [71:0]  m_tdata
);
	item_t q_item;
	logic  q_valid, q_ready;
	res_t  res;

	xalu_front u_front (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.op(s_tdata[3:0]), .size_code(s_tdata[5:4]),
		.src_operand(s_tdata[37:6]), .dest_operand(s_tdata[69:38]),
		.dest_upper(s_tdata[101:70]),
		.q_valid, .q_ready, .q_item
	);

	xalu_back u_back (
		.clk, .arst_n,
		.q_valid, .q_ready, .q_item,
		.r_valid(m_tvalid), .r_ready(m_tready), .r_res(res)
	);

	assign m_tdata = {2'b00, res.derr, res.flags[4], res.flags[3], res.flags[2],
		res.flags[1], res.flags[0], res.hi, res.lo};

	`ALU_ASSERT_IMP(a_derr_zero, m_tvalid && m_tdata[69], m_tdata[63:0] == 64'd0,
		"divide error with nonzero result")
	`ALU_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid, "result dropped")
endmodule

// ===== tb/tb_x86_integer_alu_with_flags.sv =====
// Self-checking bench for the x86 integer ALU with flags: directed and random words
// through the stream ports, each result compared with a local flag-keeping ALU model.
// Depends on xalu_pkg and the x86_integer_alu_with_flags RTL.
`timescale 1ns / 1ps
module tb_x86_integer_alu_with_flags;
	import xalu_pkg::*;

	localparam int unsigned WatchdogLimit = 4000;
	localparam int unsigned DrainCycles   = 100;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [71:0]  m_tdata;

	// Expected result words, oldest first; each is lo, hi, flags, divide error.
	typedef struct packed {
		logic [31:0] lo;
		logic [31:0] hi;
		logic [4:0]  flags;
		logic        derr;
	} alu_result_t;

	alu_result_t expected_results[$];
	logic [4:0]  model_flags;
	int          mismatch_count;
	int unsigned idle_cycles;

	// Burst and gap control for the sender.
	int unsigned burst_left;

	x86_integer_alu_with_flags DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] width_mask(input int unsigned w);
		return (w == 8) ? 32'hff : (w == 16) ? 32'hffff : 32'hffffffff;
	endfunction

	function automatic logic sign_at(input logic [31:0] v, input int unsigned w);
		return v[w-1];
	endfunction

	function automatic logic [63:0] sext_at(input logic [31:0] v, input int unsigned w);
		logic [63:0] x;
		x = {32'd0, v & width_mask(w)};
		if (sign_at(v, w))
			x = x | ~{32'd0, width_mask(w)};
		return x;
	endfunction

	// Sets PF, ZF and SF from a result at width w.
	function automatic logic [4:0] with_pzs(input logic [4:0] f, input logic [31:0] r,
			input int unsigned w);
		logic [4:0] g;
		g = f;
		g[1] = ~^r[7:0];
		g[2] = ((r & width_mask(w)) == 32'd0);
		g[3] = sign_at(r, w);
		return g;
	endfunction

	// Computes one ALU result and advances the model's flag register.
	function automatic alu_result_t alu_compute(input op_t op, input logic [1:0] size_code,
			input logic [31:0] src, input logic [31:0] dst, input logic [31:0] upper);
		int unsigned w;
		logic [31:0] m, s, d, lo, hi;
		logic [4:0]  f;
		logic [63:0] wide, sub, prod, dividend, ua, ub, q, r;
		logic        derr, nn, dn, cin;
		int unsigned cnt;
		alu_result_t res;
		w = (size_code == 2'd0) ? 8 : (size_code == 2'd1) ? 16 : 32;
		m = width_mask(w);
		s = src & m;
		d = dst & m;
		f = model_flags;
		cin = f[0];
		lo = 32'd0;
		hi = 32'd0;
		derr = 1'b0;
		cnt = 32'(src[4:0]);
		dividend = {upper, dst};
		case (op)
			OP_ADD, OP_ADC: begin
				wide = 64'(s) + 64'(d) + ((op == OP_ADC) ? 64'(cin) : 64'd0);
				lo = wide[31:0] & m;
				f[0] = wide[w];
				f[4] = sign_at(~(d ^ s) & (d ^ lo), w);
				f = with_pzs(f, lo, w);
			end
			OP_SUB, OP_SBB: begin
				sub = 64'(s) + ((op == OP_SBB) ? 64'(cin) : 64'd0);
				wide = 64'(d) - sub;
				lo = wide[31:0] & m;
				f[0] = (64'(d) < sub);
				f[4] = sign_at((d ^ s) & (d ^ lo), w);
				f = with_pzs(f, lo, w);
			end
			OP_AND, OP_OR, OP_XOR: begin
				lo = (op == OP_AND) ? (s & d) : (op == OP_OR) ? (s | d) : (s ^ d);
				f[0] = 1'b0;
				f[4] = 1'b0;
				f = with_pzs(f, lo, w);
			end
			OP_SHL: begin
				lo = d;
				if (cnt != 0) begin
					wide = 64'(d) << cnt;
					lo = wide[31:0] & m;
					f[0] = (cnt <= w) ? d[w-cnt] : 1'b0;
					if (cnt == 1)
						f[4] = sign_at(lo, w) ^ f[0];
					f = with_pzs(f, lo, w);
				end
			end
			OP_SHR: begin
				lo = d;
				if (cnt != 0) begin
					lo = d >> cnt;
					f[0] = (cnt <= w) ? d[cnt-1] : 1'b0;
					if (cnt == 1)
						f[4] = sign_at(d, w);
					f = with_pzs(f, lo, w);
				end
			end
			OP_SAR: begin
				lo = d;
				if (cnt != 0) begin
					wide = sext_at(d, w);
					r = $signed(wide) >>> cnt;
					lo = r[31:0] & m;
					f[0] = wide[cnt-1];
					if (cnt == 1)
						f[4] = 1'b0;
					f = with_pzs(f, lo, w);
				end
			end
			OP_MUL: begin
				prod = 64'(s) * 64'(d);
				lo = prod[31:0];
				hi = prod[63:32];
				f[0] = ((prod >> w) != 64'd0);
				f[4] = f[0];
			end
			OP_IMUL: begin
				prod = sext_at(s, w) * sext_at(d, w);
				lo = prod[31:0];
				hi = prod[63:32];
				f[0] = (prod != sext_at(prod[31:0], w));
				f[4] = f[0];
			end
			default: begin
				if (s == 32'd0) begin
					derr = 1'b1;
				end else if (op == OP_DIV || op == OP_MOD) begin
					q = dividend / 64'(s);
					r = dividend % 64'(s);
					lo = ((op == OP_DIV) ? q[31:0] : r[31:0]) & m;
				end else begin
					// Signed division on magnitudes; remainder follows the dividend.
					nn = dividend[63];
					dn = sign_at(s, w);
					ua = nn ? -dividend : dividend;
					ub = dn ? -sext_at(s, w) : 64'(s);
					q = ua / ub;
					r = ua % ub;
					if (nn != dn)
						q = -q;
					if (nn)
						r = -r;
					lo = ((op == OP_IDIV) ? q[31:0] : r[31:0]) & m;
				end
			end
		endcase
		model_flags = f;
		res.lo = lo;
		res.hi = hi;
		res.flags = f;
		res.derr = derr;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// Sends one word, with the sender's burst and gap pattern around it.
	task automatic send_word(input op_t op, input logic [1:0] size_code,
			input logic [31:0] src, input logic [31:0] dst, input logic [31:0] upper);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
		end
		burst_left--;
		s_tdata <= {2'b00, upper, dst, src, size_code, 4'(op)};
		s_tvalid <= 1'b1;
		expected_results.push_back(alu_compute(op, size_code, src, dst, upper));
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Stops sending and waits until every expected result has come back.
	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] edge_value();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hffffffff;
			2: return 32'h80000000;
			3: return 32'h7fffffff;
			4: return 32'h80;
			5: return 32'h8000;
			6: return 32'd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_extremes();
		send_word(OP_ADD, 2'd0, 32'hff, 32'h01, 32'd0);
		send_word(OP_ADC, 2'd1, 32'hffff, 32'hffff, 32'd0);
		send_word(OP_ADD, 2'd2, 32'h7fffffff, 32'd1, 32'd0);
		send_word(OP_SUB, 2'd2, 32'd1, 32'd0, 32'd0);
		send_word(OP_SBB, 2'd0, 32'h7f, 32'h80, 32'd0);
		send_word(OP_AND, 2'd3, 32'hffffffff, 32'hffffffff, 32'hffffffff);
		send_word(OP_OR, 2'd1, 32'd0, 32'd0, 32'd0);
		send_word(OP_XOR, 2'd0, 32'hffffff55, 32'h000000aa, 32'd0);
	endtask

	task automatic test_shifts();
		// Count of zero keeps flags; count one, count at width and beyond it.
		send_word(OP_SHL, 2'd0, 32'd1, 32'h81, 32'd0);
		send_word(OP_SHL, 2'd0, 32'd32, 32'h55, 32'd0);
		send_word(OP_SHL, 2'd0, 32'd8, 32'h01, 32'd0);
		send_word(OP_SHR, 2'd1, 32'd1, 32'h8001, 32'd0);
		send_word(OP_SHR, 2'd0, 32'd20, 32'hff, 32'd0);
		send_word(OP_SAR, 2'd0, 32'd1, 32'h81, 32'd0);
		send_word(OP_SAR, 2'd1, 32'd31, 32'h8000, 32'd0);
		send_word(OP_SAR, 2'd2, 32'hffffffe5, 32'h80000000, 32'd0);
	endtask

	task automatic test_multiply_divide();
		send_word(OP_MUL, 2'd2, 32'hffffffff, 32'hffffffff, 32'd0);
		send_word(OP_IMUL, 2'd0, 32'h80, 32'h80, 32'd0);
		send_word(OP_DIV, 2'd2, 32'd0, 32'd5, 32'd1);
		send_word(OP_DIV, 2'd2, 32'd7, 32'hffffffff, 32'hffffffff);
		send_word(OP_IDIV, 2'd0, 32'hff, 32'h80, 32'hffffffff);
		send_word(OP_MOD, 2'd1, 32'd10, 32'd12345, 32'd0);
		send_word(OP_IMOD, 2'd2, 32'h80000000, 32'd3, 32'h80000000);
		send_word(OP_IMOD, 2'd1, 32'd0, 32'd1, 32'd0);
	endtask

	task automatic test_random_words(input int unsigned count);
		op_t         op;
		logic [31:0] src;
		for (int unsigned i = 0; i < count; i++) begin
			// Divisions are slow; keep them to about a quarter of the mix.
			op = op_t'(($urandom_range(0, 3) == 0) ? $urandom_range(12, 15)
				: $urandom_range(0, 11));
			src = $urandom_range(0, 1) ? edge_value() : $urandom;
			if (op == OP_SHL || op == OP_SHR || op == OP_SAR)
				if ($urandom_range(0, 1))
					src = ($urandom & 32'hffffffe0) | 32'($urandom_range(0, 31));
			send_word(op, 2'($urandom_range(0, 3)), src,
				$urandom_range(0, 1) ? edge_value() : $urandom,
				$urandom_range(0, 2) ? $urandom : edge_value());
			// Once along the way, let every result come home before going on.
			if (i == count / 2)
				wait_all_results();
		end
	endtask

	// Receiver stall pattern: long open stretches mixed with random stalls.
	int unsigned stall_phase;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			if (stall_phase[8:7] == 2'd3)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	// Checks each accepted result word against the oldest expectation.
	always @(posedge clk) begin
		alu_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected word", m_tdata[31:0], 32'd0);
			end else begin
				want = expected_results.pop_front();
				if (m_tdata[31:0] != want.lo)
					report_mismatch("result_low", m_tdata[31:0], want.lo);
				if (m_tdata[63:32] != want.hi)
					report_mismatch("result_high", m_tdata[63:32], want.hi);
				if (m_tdata[68:64] != want.flags)
					report_mismatch("flags", 32'(m_tdata[68:64]), 32'(want.flags));
				if (m_tdata[69] != want.derr)
					report_mismatch("divide_error", 32'(m_tdata[69]), 32'(want.derr));
			end
		end
	end

	// Watchdog on cycles with nothing accepted on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WatchdogLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		model_flags = 5'd0;
		mismatch_count = 0;
		idle_cycles = 0;
		burst_left = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_shifts();
		test_multiply_divide();
		test_random_words(550);
		wait_all_results();
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
